// File: hw/rtl/polar_bilinear_table_lookup_core_assert.svh
// assertion macros used by the checker file
// no dependencies
`ifndef POLAR_BILINEAR_TABLE_LOOKUP_CORE_ASSERT_SVH
`define POLAR_BILINEAR_TABLE_LOOKUP_CORE_ASSERT_SVH
`define PBT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: hw/rtl/pbtl_pkg.sv
// shared types and constants for the polar table lookup
// no dependencies
package pbtl_pkg;
   localparam logic [1:0] KIND_WR_ANGLE = 2'd0;
   localparam logic [1:0] KIND_WR_WIND  = 2'd1;
   localparam logic [1:0] KIND_WR_CELL  = 2'd2;
   localparam logic [1:0] KIND_QUERY    = 2'd3;

   localparam logic [1:0] CSR_READY = 2'd0;
   localparam logic [1:0] CSR_ROWS  = 2'd1;
   localparam logic [1:0] CSR_COLS  = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [4:0]         row;
      logic [3:0]         col;
      logic signed [15:0] angle;
      logic [15:0]        wind;
      logic [15:0]        cell_speed;
   } req_type;

   typedef struct packed {
      logic [15:0] speed;
      logic        valid_res;
   } rsp_type;

   // divider handshake
   typedef struct packed {
      logic        start;
      logic [16:0] num;
      logic [16:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic        done;
      logic [16:0] quot;
   } div_res_type;
endpackage

// File: hw/rtl/polar_bilinear_table_lookup_core.sv
// Polar table lookup: a query runs a one-entry-a-cycle bracket search over the angle rows and
// then the wind columns, forms the two fractions in turn on the shared bit-serial divider,
// reads the four grid cells, takes 6 steps on one shared 17x34 multiplier and then presents
// the result through ST_DONE, which registers it, and ST_OUT, which raises rsp_valid.
// A query that finds the table not ready or too small gives its result the next cycle.
// Writes give no result. req_stall is high while a item is in work or a result waits.
module polar_bilinear_table_lookup_core #(
   parameter int MAX_ANGLE_ROWS = 32,
   parameter int MAX_WIND_COLS  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pbtl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pbtl_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [5:0]        csr_data
);
   import pbtl_pkg::*;

   localparam int RW = $clog2(MAX_ANGLE_ROWS);
   localparam int CW = $clog2(MAX_WIND_COLS);
   localparam int GW = RW + CW;
   localparam int GD = MAX_ANGLE_ROWS * MAX_WIND_COLS;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ASRCH, ST_WSRCH, ST_ADIV, ST_WDIV, ST_CELL,
      ST_MUL, ST_DONE, ST_OUT
   } state_type;

   logic signed [15:0] angle_mem [MAX_ANGLE_ROWS];
   logic [15:0]        wind_mem  [MAX_WIND_COLS];
   logic [15:0]        grid_mem  [GD];

   logic        ready_ff;
   logic [5:0]  rows_ff;
   logic [4:0]  cols_ff;

   state_type   st_ff;
   req_type     q_ff;
   logic [16:0] aabs_ff;
   logic [8:0]  idx_ff;
   logic [RW-1:0] r1_ff;
   logic [CW-1:0] c1_ff;
   logic [16:0] nr_ff, nc_ff;
   logic signed [16:0] a0_ff, a1_ff;
   logic [15:0] w0_ff, w1_ff;
   logic [16:0] tf_ff, sf_ff;
   logic [15:0] s_ff [4];
   logic [2:0]  step_ff;
   logic [1:0]  sub_ff;
   logic [33:0] lo_ff, hi_ff, prod_ff;
   logic [49:0] acc_ff;
   logic        dstart_ff;
   div_cmd_type dcmd;
   div_res_type dres;
   rsp_type     rsp_ff;
   logic        rspv_ff;
   logic [15:0] grid_rd_ff;

   logic [16:0] nrsat, ncsat;
   logic [GW-1:0] grid_addr;
   logic [33:0] mop_a;
   logic [16:0] mop_b;
   logic [50:0] mprod;
   logic signed [17:0] anum, aden;
   logic [16:0] wnum, wden;
   logic [50:0] rnd;

   assign nrsat = (rows_ff > 6'(MAX_ANGLE_ROWS > 63 ? 63 : MAX_ANGLE_ROWS))
                  ? 17'(MAX_ANGLE_ROWS) : 17'(rows_ff);
   assign ncsat = (cols_ff > 5'(MAX_WIND_COLS > 31 ? 31 : MAX_WIND_COLS))
                  ? 17'(MAX_WIND_COLS) : 17'(cols_ff);

   assign req_stall = (st_ff != ST_IDLE) || rspv_ff;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   assign anum = 18'(signed'({1'b0, aabs_ff})) - 18'(a0_ff);
   assign aden = 18'(a1_ff) - 18'(a0_ff);
   assign wnum = 17'(q_ff.wind) - 17'(w0_ff);
   assign wden = 17'(w1_ff) - 17'(w0_ff);

   always_comb begin
      dcmd = '0;
      dcmd.start = dstart_ff;
      if (st_ff == ST_ADIV) begin
         // opposite signs give zero; both negative keeps magnitude
         if (anum[17] != aden[17]) begin
            dcmd.num = '0;
         end else if (anum[17]) begin
            dcmd.num = 17'(-anum);
         end else begin
            dcmd.num = anum[16:0];
         end
         dcmd.den = aden[17] ? 17'(-aden) : aden[16:0];
      end else begin
         if (wnum[16] != wden[16]) begin
            dcmd.num = '0;
         end else begin
            dcmd.num = wnum[16] ? 17'(-wnum) : wnum;
         end
         dcmd.den = wden[16] ? 17'(-wden) : wden;
      end
   end

   pbtl_div u_div (.clock(clock), .reset(reset), .cmd(dcmd), .res(dres));

   // cell order: s00 s01 s10 s11
   always_comb begin
      grid_addr = {(sub_ff[1] ? r1_ff : RW'(r1_ff - 1'b1)),
                   (sub_ff[0] ? c1_ff : CW'(c1_ff - 1'b1))};
   end

   // shared multiplier: lo, hi, then acc in two halves of weight
   always_comb begin
      case (step_ff)
         3'd0: begin mop_a = 34'(s_ff[0]); mop_b = 17'(17'd65536 - tf_ff); end
         3'd1: begin mop_a = 34'(s_ff[2]); mop_b = tf_ff; end
         3'd2: begin mop_a = 34'(s_ff[1]); mop_b = 17'(17'd65536 - tf_ff); end
         3'd3: begin mop_a = 34'(s_ff[3]); mop_b = tf_ff; end
         3'd4: begin mop_a = lo_ff; mop_b = 17'(17'd65536 - sf_ff); end
         3'd5: begin mop_a = hi_ff; mop_b = sf_ff; end
         default: begin mop_a = '0; mop_b = '0; end
      endcase
      mprod = 51'(mop_a) * 51'(mop_b);
   end

   assign rnd = 51'(acc_ff) + 51'h80000000;

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         if (req_data.kind == KIND_WR_ANGLE && 32'(req_data.row) < MAX_ANGLE_ROWS) begin
            angle_mem[RW'(req_data.row)] <= req_data.angle;
         end
         if (req_data.kind == KIND_WR_WIND && 32'(req_data.col) < MAX_WIND_COLS) begin
            wind_mem[CW'(req_data.col)] <= req_data.wind;
         end
         if (req_data.kind == KIND_WR_CELL && 32'(req_data.row) < MAX_ANGLE_ROWS
             && 32'(req_data.col) < MAX_WIND_COLS) begin
            grid_mem[{RW'(req_data.row), CW'(req_data.col)}] <= req_data.cell_speed;
         end
      end
      grid_rd_ff <= grid_mem[grid_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff  <= 1'b0;
         rows_ff   <= 6'd2;
         cols_ff   <= 5'd2;
         st_ff     <= ST_IDLE;
         rspv_ff   <= 1'b0;
         dstart_ff <= 1'b0;
      end else begin
         dstart_ff <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               CSR_READY: ready_ff <= csr_data[0];
               CSR_ROWS:  rows_ff  <= csr_data;
               CSR_COLS:  cols_ff  <= csr_data[4:0];
               default: ;
            endcase
         end
         if (rspv_ff && !rsp_stall) rspv_ff <= 1'b0;
         case (st_ff)
            ST_IDLE: begin
               if (req_valid && !req_stall && req_data.kind == KIND_QUERY) begin
                  q_ff    <= req_data;
                  aabs_ff <= req_data.angle[15] ? 17'(-18'(req_data.angle))
                                                : 17'(req_data.angle);
                  nr_ff   <= nrsat;
                  nc_ff   <= ncsat;
                  if (!ready_ff || nrsat < 17'd2 || ncsat < 17'd2) begin
                     rsp_ff  <= '0;
                     rspv_ff <= 1'b1;
                  end else begin
                     idx_ff <= 9'd1;
                     st_ff  <= ST_ASRCH;
                  end
               end
            end
            ST_ASRCH: begin
               if (17'(idx_ff) < nr_ff - 17'd1 &&
                   signed'({1'b0, aabs_ff}) > 18'(angle_mem[RW'(idx_ff)])) begin
                  idx_ff <= idx_ff + 9'd1;
               end else begin
                  r1_ff  <= RW'(idx_ff);
                  a0_ff  <= 17'(angle_mem[RW'(idx_ff - 9'd1)]);
                  a1_ff  <= 17'(angle_mem[RW'(idx_ff)]);
                  idx_ff <= 9'd1;
                  st_ff  <= ST_WSRCH;
               end
            end
            ST_WSRCH: begin
               if (17'(idx_ff) < nc_ff - 17'd1 && q_ff.wind > wind_mem[CW'(idx_ff)]) begin
                  idx_ff <= idx_ff + 9'd1;
               end else begin
                  c1_ff     <= CW'(idx_ff);
                  w0_ff     <= wind_mem[CW'(idx_ff - 9'd1)];
                  w1_ff     <= wind_mem[CW'(idx_ff)];
                  dstart_ff <= 1'b1;
                  st_ff     <= ST_ADIV;
               end
            end
            ST_ADIV: begin
               if (dres.done) begin
                  tf_ff     <= dres.quot;
                  dstart_ff <= 1'b1;
                  st_ff     <= ST_WDIV;
               end
            end
            ST_WDIV: begin
               if (dres.done) begin
                  sf_ff  <= dres.quot;
                  sub_ff <= 2'd0;
                  idx_ff <= 9'd0;
                  st_ff  <= ST_CELL;
               end
            end
            ST_CELL: begin
               // address presented first, registered read data captured the next cycle
               if (idx_ff[0]) begin
                  s_ff[sub_ff] <= grid_rd_ff;
                  if (sub_ff == 2'd3) begin
                     step_ff <= 3'd0;
                     st_ff   <= ST_MUL;
                  end else begin
                     sub_ff <= sub_ff + 2'd1;
                  end
               end
               idx_ff <= {8'd0, ~idx_ff[0]};
            end
            ST_MUL: begin
               prod_ff <= mprod[33:0];
               step_ff <= step_ff + 3'd1;
               case (step_ff)
                  3'd1: lo_ff  <= prod_ff + mprod[33:0];
                  3'd3: hi_ff  <= prod_ff + mprod[33:0];
                  3'd4: acc_ff <= mprod[49:0];
                  3'd5: begin
                     acc_ff <= acc_ff + mprod[49:0];
                     st_ff  <= ST_DONE;
                  end
                  default: ;
               endcase
            end
            ST_DONE: begin
               rsp_ff.valid_res <= 1'b1;
               rsp_ff.speed     <= (rnd[50:32] > 19'hFFFF) ? 16'hFFFF : rnd[47:32];
               st_ff            <= ST_OUT;
            end
            ST_OUT: begin
               rspv_ff <= 1'b1;
               st_ff   <= ST_IDLE;
            end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// File: hw/rtl/pbtl_div.sv
// restoring divider forming a clamped Q1.16 fraction num/den, one bit a cycle
// depends on pbtl_pkg
module pbtl_div (
   input  logic                 clock,
   input  logic                 reset,
   input  pbtl_pkg::div_cmd_type cmd,
   output pbtl_pkg::div_res_type res
);
   import pbtl_pkg::*;

   logic [33:0] rem_ff, rem_in;
   logic [16:0] den_ff, den_in;
   logic [16:0] quot_ff, quot_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        zero_ff, zero_in;
   logic [34:0] trial;

   // numerator is (num << 16), shifted in msb first; 17 quotient bits cover 65536
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      zero_in = zero_ff;
      done_in = 1'b0;
      trial   = '0;
      if (cmd.start) begin
         rem_in  = {cmd.num, 17'd0};
         den_in  = cmd.den;
         quot_in = '0;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
         zero_in = (cmd.den == 17'd0) || (cmd.num == 17'd0);
      end else if (busy_ff) begin
         trial = {1'b0, rem_ff[33:17], 17'd0} - {1'b0, den_ff, 17'd0};
         if (!trial[34]) begin
            rem_in  = {trial[32:17], rem_ff[16:0], 1'b0};
            quot_in = {quot_ff[15:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[32:0], 1'b0};
            quot_in = {quot_ff[15:0], 1'b0};
         end
         // carry of the shifted remainder is absorbed since rem < den before shift
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd16) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      res.done = done_ff;
      if (zero_ff) begin
         res.quot = '0;
      end else if (quot_ff > 17'd65536) begin
         res.quot = 17'd65536;
      end else begin
         res.quot = quot_ff;
      end
   end
endmodule

// File: hw/rtl/pbtl_checker.sv
// port-level checks for the polar table lookup, bound to the top level
// depends on pbtl_pkg and the assertion macro header
`include "polar_bilinear_table_lookup_core_assert.svh"
module pbtl_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pbtl_pkg::rsp_type rsp_data
);
   import pbtl_pkg::*;

   `PBT_ASSERT_IMPL(a_busy_when_rsp, clock, reset, rsp_valid, req_stall)
   `PBT_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data))
   `PBT_ASSERT_IMPL(a_invalid_zero, clock, reset, rsp_valid && !rsp_data.valid_res,
      rsp_data.speed == 16'd0)
endmodule

bind polar_bilinear_table_lookup_core pbtl_checker u_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
